>>> design/ipms_pkg.sv
`timescale 1ns / 1ps
// Package for the integer pair move search core: sizes, codes, word types
// and the step table of the move cells. No dependencies.
package ipms_pkg;

  localparam int MAX_VARS   = 64;
  localparam int MAX_ROWS   = 64;
  localparam int VAR_W      = $clog2(MAX_VARS);
  localparam int ROW_W      = $clog2(MAX_ROWS);
  localparam int CNT_W      = 7;
  localparam int COEF_AW    = ROW_W + VAR_W;
  localparam int COEF_DEPTH = MAX_ROWS * MAX_VARS;
  localparam int N_CELLS    = 8;
  localparam int CELL_W     = $clog2(N_CELLS);
  localparam int ONE_Q16    = 65536;

  // request codes
  typedef enum logic [1:0] {
    REQ_COEF  = 2'd0,
    REQ_ROW   = 2'd1,
    REQ_VAR   = 2'd2,
    REQ_START = 2'd3
  } req_t;

  // configuration register indexes
  localparam logic [1:0] CFG_VARS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;
  localparam logic [1:0] CFG_TOL  = 2'd2;

  // signed step codes
  localparam logic signed [1:0] STEP_NEG  = -2'sd1;
  localparam logic signed [1:0] STEP_ZERO = 2'sd0;
  localparam logic signed [1:0] STEP_POS  = 2'sd1;

  // per-variable data word
  typedef struct packed {
    logic signed [31:0] cost;
    logic signed [31:0] value;
    logic signed [31:0] lower;
    logic signed [31:0] upper;
  } var_t;

  // per-row data word
  typedef struct packed {
    logic signed [31:0] rhs;
    logic signed [31:0] act;
  } row_t;

  // row word that travels down the cell chain
  typedef struct packed {
    logic               valid;
    logic signed [31:0] ai;
    logic signed [31:0] aj;
    logic signed [31:0] rhs;
    logic signed [31:0] act;
  } rowword_t;

  // cell k covers step pair k in scan order, (0,0) left out
  function automatic logic signed [1:0] cell_step_i(input logic [CELL_W-1:0] k);
    logic signed [1:0] s;
    if (k < CELL_W'(3)) s = STEP_NEG;
    else if (k < CELL_W'(5)) s = STEP_ZERO;
    else s = STEP_POS;
    return s;
  endfunction

  function automatic logic signed [1:0] cell_step_j(input logic [CELL_W-1:0] k);
    logic signed [1:0] s;
    case (k)
      3'd0, 3'd3, 3'd5: s = STEP_NEG;
      3'd1, 3'd6:       s = STEP_ZERO;
      default:          s = STEP_POS;
    endcase
    return s;
  endfunction

  // v times a step of -1, 0 or +1
  function automatic logic signed [32:0] step_term(input logic signed [31:0] v,
                                                   input logic signed [1:0] s);
    logic signed [32:0] t;
    if (s == STEP_POS) t = 33'(v);
    else if (s == STEP_NEG) t = -33'(v);
    else t = '0;
    return t;
  endfunction

  // new value stays within bounds
  function automatic logic bound_ok(input var_t v, input logic signed [1:0] s);
    logic signed [33:0] nv;
    nv = 34'(v.value) + 34'(step_term(32'(ONE_Q16), s));
    return (nv >= 34'(v.lower)) && (nv <= 34'(v.upper));
  endfunction

endpackage

>>> design/integer_pair_move_search_core.sv
`timescale 1ns / 1ps
// Integer pair move search core: stores, sequencer and cell chain.
// Depends on ipms_pkg, ipms_ram and ipms_cell.
//
// Input channel (in_valid / in_stall) carries load words and start words.
// Coefficient, row and variable loads are taken one per cycle while the
// sequencer is idle and give no result. A start word scans every pair i<j
// and the eight step pairs and gives one result word on the res_valid /
// res_stall channel. For each pair the sequencer reads the variable data,
// streams each row in use (row_count taken at most 64) into the
// eight-cell chain, drains the chain, picks the best cell in scan order
// and advances.
// After reset the coefficient memory is swept to zero, one entry a cycle,
// all 4096 entries, in_stall high; config writes are taken meanwhile.
// cfg_ready is always high; write config only while the block is idle.
// While a result waits under res_stall, loads are still taken but a new
// start word is stalled until the result has left.
module integer_pair_move_search_core
  import ipms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         req_type,
  input  logic [5:0]         row_index,
  input  logic [5:0]         var_index,
  input  logic signed [31:0] coef_value,
  input  logic signed [31:0] rhs_value,
  input  logic signed [31:0] activity_value,
  input  logic signed [31:0] cost_value,
  input  logic signed [31:0] current_value,
  input  logic signed [31:0] lower_bound,
  input  logic signed [31:0] upper_bound,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               res_valid,
  input  logic               res_stall,
  output logic               move_found,
  output logic signed [32:0] delta_objective,
  output logic [5:0]         first_var,
  output logic [5:0]         second_var,
  output logic signed [1:0]  first_step,
  output logic signed [1:0]  second_step
);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_VREAD, S_VLOAD, S_ROWS, S_DRAIN, S_PICK, S_NEXT, S_DONE
  } state_t;

  state_t             state;
  logic [COEF_AW-1:0] clr_addr;
  logic [CNT_W-1:0]   var_cnt, row_cnt, nv, nr, r;
  logic [15:0]        tol;
  logic [VAR_W-1:0]   i, j;
  logic [CELL_W:0]    cnt;
  logic               issue_d;
  logic               best_valid;
  logic signed [33:0] best_delta;
  logic [VAR_W-1:0]   best_i, best_j;
  logic signed [1:0]  best_di, best_dj;

  logic               in_fire;
  logic [CNT_W-1:0]   nv_clamp, nr_clamp;
  logic               coef_we;
  logic [COEF_AW-1:0] coef_waddr;
  logic [31:0]        coef_wdata;
  logic [31:0]        coef_a, coef_b;
  row_t               row_wdata, row_rd;
  var_t               var_wdata, vi, vj;
  rowword_t           chain [N_CELLS];
  logic               cell_ok [N_CELLS];
  logic signed [33:0] cell_delta [N_CELLS];
  logic [CELL_W-1:0]  sel;

  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE) || (res_valid && req_type == REQ_START);
  assign nv_clamp  = (var_cnt > CNT_W'(MAX_VARS)) ? CNT_W'(MAX_VARS) : var_cnt;
  assign nr_clamp  = (row_cnt > CNT_W'(MAX_ROWS)) ? CNT_W'(MAX_ROWS) : row_cnt;
  assign sel       = cnt[CELL_W-1:0];

  // coefficient memory: zero sweep after reset, then loads
  assign coef_we    = (state == S_CLEAR) || (in_fire && req_type == REQ_COEF);
  assign coef_waddr = (state == S_CLEAR) ? clr_addr : {row_index, var_index};
  assign coef_wdata = (state == S_CLEAR) ? '0 : coef_value;

  ipms_ram #(.WIDTH(32), .DEPTH(COEF_DEPTH)) u_coef (
    .clk     (clk),
    .we      (coef_we),
    .waddr   (coef_waddr),
    .wdata   (coef_wdata),
    .raddr_a ({r[ROW_W-1:0], i}),
    .raddr_b ({r[ROW_W-1:0], j}),
    .rdata_a (coef_a),
    .rdata_b (coef_b)
  );

  // row memory
  assign row_wdata = '{rhs: rhs_value, act: activity_value};

  ipms_ram #(.WIDTH($bits(row_t)), .DEPTH(MAX_ROWS)) u_row (
    .clk     (clk),
    .we      (in_fire && req_type == REQ_ROW),
    .waddr   (row_index),
    .wdata   (row_wdata),
    .raddr_a (r[ROW_W-1:0]),
    .raddr_b (r[ROW_W-1:0]),
    .rdata_a (row_rd),
    .rdata_b ()
  );

  // variable memory, read at both variables of the pair
  assign var_wdata = '{cost: cost_value, value: current_value,
                       lower: lower_bound, upper: upper_bound};

  ipms_ram #(.WIDTH($bits(var_t)), .DEPTH(MAX_VARS)) u_var (
    .clk     (clk),
    .we      (in_fire && req_type == REQ_VAR),
    .waddr   (var_index),
    .wdata   (var_wdata),
    .raddr_a (i),
    .raddr_b (j),
    .rdata_a (vi),
    .rdata_b (vj)
  );

  // row word entering the chain
  assign chain[0] = '{valid: issue_d, ai: coef_a, aj: coef_b,
                      rhs: row_rd.rhs, act: row_rd.act};

  // cell chain, one cell per step pair
  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    rowword_t word_out;

    ipms_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .step_i   (cell_step_i(CELL_W'(k))),
      .step_j   (cell_step_j(CELL_W'(k))),
      .load     (state == S_VLOAD),
      .var_i    (vi),
      .var_j    (vj),
      .tol      (tol),
      .word_in  (chain[k]),
      .word_out (word_out),
      .ok       (cell_ok[k]),
      .delta    (cell_delta[k])
    );

    if (k < N_CELLS - 1) begin : g_link
      assign chain[k+1] = word_out;
    end
  end

  // sequencer, config registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clr_addr   <= '0;
      var_cnt    <= CNT_W'(64);
      row_cnt    <= CNT_W'(64);
      tol        <= 16'd1;
      issue_d    <= 1'b0;
      res_valid  <= 1'b0;
      best_valid <= 1'b0;
    end else begin
      issue_d <= (state == S_ROWS);

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_VARS: var_cnt <= cfg_data[CNT_W-1:0];
          CFG_ROWS: row_cnt <= cfg_data[CNT_W-1:0];
          CFG_TOL:  tol     <= cfg_data;
          default:  ;
        endcase
      end

      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end

      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == COEF_AW'(COEF_DEPTH - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (in_fire && req_type == REQ_START) begin
            nv         <= nv_clamp;
            nr         <= nr_clamp;
            best_valid <= 1'b0;
            best_delta <= '0;
            best_i     <= '0;
            best_j     <= '0;
            best_di    <= STEP_ZERO;
            best_dj    <= STEP_ZERO;
            i          <= '0;
            j          <= VAR_W'(1);
            state      <= (nv_clamp < CNT_W'(2)) ? S_DONE : S_VREAD;
          end
        end
        S_VREAD: state <= S_VLOAD;
        S_VLOAD: begin
          r     <= '0;
          cnt   <= '0;
          state <= (nr == '0) ? S_DRAIN : S_ROWS;
        end
        S_ROWS: begin
          r <= r + 1'b1;
          if (r == nr - 1'b1) state <= S_DRAIN;
        end
        S_DRAIN: begin
          cnt <= cnt + 1'b1;
          if (cnt == (CELL_W+1)'(N_CELLS)) begin
            cnt   <= '0;
            state <= S_PICK;
          end
        end
        S_PICK: begin
          // strict compare in scan order keeps the first of equal deltas
          if (cell_ok[sel] && cell_delta[sel] < best_delta) begin
            best_valid <= 1'b1;
            best_delta <= cell_delta[sel];
            best_i     <= i;
            best_j     <= j;
            best_di    <= cell_step_i(sel);
            best_dj    <= cell_step_j(sel);
          end
          cnt <= cnt + 1'b1;
          if (cnt == (CELL_W+1)'(N_CELLS - 1)) state <= S_NEXT;
        end
        S_NEXT: begin
          if ({1'b0, j} == nv - 1'b1) begin
            if ({1'b0, i} == nv - CNT_W'(2)) begin
              state <= S_DONE;
            end else begin
              i     <= i + 1'b1;
              j     <= i + VAR_W'(2);
              state <= S_VREAD;
            end
          end else begin
            j     <= j + 1'b1;
            state <= S_VREAD;
          end
        end
        S_DONE: begin
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // result word payload; a kept delta is negative and fits 33 bits
  always_ff @(posedge clk) begin
    if (state == S_DONE) begin
      move_found      <= best_valid;
      delta_objective <= best_delta[32:0];
      first_var       <= best_i;
      second_var      <= best_j;
      first_step      <= best_di;
      second_step     <= best_dj;
    end
  end

endmodule

>>> design/ipms_ram.sv
`timescale 1ns / 1ps
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module ipms_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> design/ipms_cell.sv
`timescale 1ns / 1ps
// Move cell: holds one step pair's delta and feasibility for the current
// variable pair, checks each passing row word. Depends on ipms_pkg.
module ipms_cell
  import ipms_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic signed [1:0]  step_i,
  input  logic signed [1:0]  step_j,
  input  logic               load,
  input  var_t               var_i,
  input  var_t               var_j,
  input  logic [15:0]        tol,
  input  rowword_t           word_in,
  output rowword_t           word_out,
  output logic               ok,
  output logic signed [33:0] delta
);

  logic               touched;
  logic signed [34:0] lhs;
  logic signed [34:0] lim;
  logic               row_fail;

  // row check: activity + change against rhs + tolerance
  always_comb begin
    touched = (step_i != STEP_ZERO && word_in.ai != '0) ||
              (step_j != STEP_ZERO && word_in.aj != '0);
    lhs = 35'(word_in.act) + 35'(step_term(word_in.ai, step_i)) +
          35'(step_term(word_in.aj, step_j));
    lim = 35'(word_in.rhs) + 35'(signed'({1'b0, tol}));
    row_fail = word_in.valid && touched && (lhs > lim);
  end

  // candidate state; the delta sum needs one bit over the result field
  always_ff @(posedge clk) begin
    if (load) begin
      ok    <= bound_ok(var_i, step_i) && bound_ok(var_j, step_j);
      delta <= 34'(step_term(var_i.cost, step_i)) + 34'(step_term(var_j.cost, step_j));
    end else if (row_fail) begin
      ok <= 1'b0;
    end
  end

  // hand the row word to the next cell
  always_ff @(posedge clk) begin
    if (rst) begin
      word_out.valid <= 1'b0;
    end else begin
      word_out.valid <= word_in.valid;
    end
    word_out.ai  <= word_in.ai;
    word_out.aj  <= word_in.aj;
    word_out.rhs <= word_in.rhs;
    word_out.act <= word_in.act;
  end

endmodule

>>> design/ipms_checker.sv
`timescale 1ns / 1ps
// Port checker for the integer pair move search core, bound to the top.
// Depends on nothing but the top level's ports.
module ipms_checker (
  input logic               clk,
  input logic               rst,
  input logic               res_valid,
  input logic               res_stall,
  input logic               move_found,
  input logic signed [32:0] delta_objective,
  input logic [5:0]         first_var,
  input logic [5:0]         second_var,
  input logic signed [1:0]  first_step,
  input logic signed [1:0]  second_step
);

  // a waiting result word stays
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid)
    else $error("result word dropped under stall");

  // no move reports all zero
  a_none: assert property (@(posedge clk) disable iff (rst)
    res_valid && !move_found |-> delta_objective == '0 && first_var == '0 &&
    second_var == '0 && first_step == '0 && second_step == '0)
    else $error("empty result not zero");

  // a found move improves and orders its variables
  a_move: assert property (@(posedge clk) disable iff (rst)
    res_valid && move_found |-> delta_objective[32] && first_var < second_var)
    else $error("found move not improving or misordered");

  // a found move moves something, with legal steps
  a_step: assert property (@(posedge clk) disable iff (rst)
    res_valid && move_found |-> (first_step != 2'sd0 || second_step != 2'sd0) &&
    first_step != -2'sd2 && second_step != -2'sd2)
    else $error("bad step in result");

  // reset empties the result register
  a_rst: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind integer_pair_move_search_core ipms_checker u_ipms_checker (.*);

>>> tb/integer_pair_move_search_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for integer_pair_move_search_core: loads random
// integer programs, runs pair move searches and checks each result word
// against an in-bench search. Depends on ipms_pkg and the core RTL.
module integer_pair_move_search_core_test;
  import ipms_pkg::*;

  localparam longint Q_ONE = 65536;
  localparam int CYCLE_LIMIT = 20000000;
  localparam int SETTLE_CYCLES = 40;
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // one result word
  typedef struct packed {
    logic               found;
    logic signed [32:0] delta;
    logic [5:0]         fvar;
    logic [5:0]         svar;
    logic signed [1:0]  fstep;
    logic signed [1:0]  sstep;
  } move_t;

  // one input word
  typedef struct {
    req_t              kind;
    logic [5:0]        row;
    logic [5:0]        col;
    logic signed [31:0] coef;
    logic signed [31:0] rhs;
    logic signed [31:0] act;
    logic signed [31:0] cost;
    logic signed [31:0] val;
    logic signed [31:0] lo;
    logic signed [31:0] hi;
  } word_t;

  logic clk, rst;
  logic in_valid, in_stall;
  logic [1:0] req_type;
  logic [5:0] row_index, var_index;
  logic signed [31:0] coef_value, rhs_value, activity_value, cost_value;
  logic signed [31:0] current_value, lower_bound, upper_bound;
  logic cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  logic [15:0] cfg_data;
  logic res_valid, res_stall;
  logic move_found;
  logic signed [32:0] delta_objective;
  logic [5:0] first_var, second_var;
  logic signed [1:0] first_step, second_step;

  integer_pair_move_search_core uut (.*);

  // shadow of the loaded program and the registers
  longint coef_mem [64][64];
  longint rhs_mem [64], act_mem [64];
  longint cost_mem [64], val_mem [64], lo_mem [64], hi_mem [64];
  int var_count, row_count, tol;

  move_t best_moves [$];
  int mismatches, words_sent, searches_sent, results_seen, moves_seen;
  int cycles;
  int hold_request;
  bit nogap_mode;
  int burst_left;

  // clock
  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // cycle counter and timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               best_moves.size());
      $display("integer_pair_move_search_core regression: fail");
      $finish;
    end
  end

  // receiver stall pattern, with a long hold when asked
  int stall_mode, mode_left, hold_left;
  logic [7:0] stall_pat;
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
      stall_mode <= 0;
      mode_left <= 0;
      hold_left <= 0;
      stall_pat <= 8'b1011_0010;
    end else if (hold_request > 0) begin
      hold_left <= hold_request;
      hold_request = 0;
      res_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= $urandom_range(0, 2);
        mode_left <= $urandom_range(20, 200);
        stall_pat <= 8'($urandom);
      end else begin
        mode_left <= mode_left - 1;
        stall_pat <= {stall_pat[6:0], stall_pat[7]};
      end
      case (stall_mode)
        0: res_stall <= 1'b0;
        1: res_stall <= 1'($urandom_range(0, 1));
        default: res_stall <= stall_pat[7];
      endcase
    end
  end

  // new value of a variable after a step stays within bounds
  function automatic bit step_fits(int v, int s);
    longint nv;
    nv = val_mem[v] + s * Q_ONE;
    return nv >= lo_mem[v] && nv <= hi_mem[v];
  endfunction

  // every touched row in use keeps activity within rhs plus slack
  function automatic bit rows_hold(int i, int j, int di, int dj, int nr);
    longint ai, aj;
    for (int r = 0; r < nr; r++) begin
      ai = coef_mem[r][i];
      aj = coef_mem[r][j];
      if (!((di != 0 && ai != 0) || (dj != 0 && aj != 0))) continue;
      if (act_mem[r] + ai * di + aj * dj > rhs_mem[r] + tol) return 0;
    end
    return 1;
  endfunction

  // sequential scan; strict compare keeps the first of equal deltas
  function automatic move_t search_best();
    move_t m;
    longint bd, d;
    int nv, nr;
    m = '0;
    bd = 0;
    nv = var_count > MAX_VARS ? MAX_VARS : var_count;
    nr = row_count > MAX_ROWS ? MAX_ROWS : row_count;
    for (int i = 0; i < nv; i++)
      for (int j = i + 1; j < nv; j++)
        for (int di = -1; di <= 1; di++) begin
          if (!step_fits(i, di)) continue;
          for (int dj = -1; dj <= 1; dj++) begin
            if (di == 0 && dj == 0) continue;
            if (!step_fits(j, dj)) continue;
            d = cost_mem[i] * di + cost_mem[j] * dj;
            if (d >= bd) continue;
            if (!rows_hold(i, j, di, dj, nr)) continue;
            bd = d;
            m.found = 1'b1;
            m.delta = d[32:0];
            m.fvar = i[5:0];
            m.svar = j[5:0];
            m.fstep = di[1:0];
            m.sstep = dj[1:0];
          end
        end
    return m;
  endfunction

  // update the shadow for an accepted word
  task automatic absorb_word(word_t w);
    case (w.kind)
      REQ_COEF: coef_mem[w.row][w.col] = w.coef;
      REQ_ROW: begin
        rhs_mem[w.row] = w.rhs;
        act_mem[w.row] = w.act;
      end
      REQ_VAR: begin
        cost_mem[w.col] = w.cost;
        val_mem[w.col] = w.val;
        lo_mem[w.col] = w.lo;
        hi_mem[w.col] = w.hi;
      end
      default: begin
        best_moves.insert(best_moves.size(), search_best());
        searches_sent++;
      end
    endcase
  endtask

  // send one word, waiting for the handshake; valid stays high after
  task automatic send_word(word_t w);
    in_valid <= 1'b1;
    req_type <= w.kind;
    row_index <= w.row;
    var_index <= w.col;
    coef_value <= w.coef;
    rhs_value <= w.rhs;
    activity_value <= w.act;
    cost_value <= w.cost;
    current_value <= w.val;
    lower_bound <= w.lo;
    upper_bound <= w.hi;
    do @(posedge clk); while (in_stall);
    absorb_word(w);
    words_sent++;
  endtask

  // sender bursts with random gaps
  task automatic paced_send(word_t w);
    int gap;
    if (!nogap_mode && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 30);
      nogap_mode = ($urandom_range(0, 5) == 0);
    end else if (burst_left > 0)
      burst_left--;
    else if ($urandom_range(0, 60) == 0)
      nogap_mode = 0;
    send_word(w);
  endtask

  // wait for all results, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (best_moves.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // register write, only while idle
  task automatic write_reg(logic [1:0] idx, logic [15:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_VARS: var_count = data[6:0];
      CFG_ROWS: row_count = data[6:0];
      CFG_TOL: tol = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(int nv, int nr, int t);
    write_reg(CFG_VARS, 16'(nv));
    write_reg(CFG_ROWS, 16'(nr));
    write_reg(CFG_TOL, 16'(t));
  endtask

  // random words: mostly well-formed data, some raw noise
  function automatic word_t blank_word(req_t k);
    word_t w;
    w.kind = k;
    w.row = 6'($urandom);
    w.col = 6'($urandom);
    w.coef = $urandom;
    w.rhs = $urandom;
    w.act = $urandom;
    w.cost = $urandom;
    w.val = $urandom;
    w.lo = $urandom;
    w.hi = $urandom;
    return w;
  endfunction

  function automatic word_t var_word(int col);
    word_t w;
    longint v;
    w = blank_word(REQ_VAR);
    w.col = 6'(col);
    if ($urandom_range(0, 9) != 0) begin
      v = (longint'($urandom_range(0, 20)) - 10) * Q_ONE +
          longint'($urandom_range(0, 3));
      w.val = 32'(v);
      w.lo = 32'(v - longint'($urandom_range(0, 2)) * Q_ONE +
                 longint'($urandom_range(0, 1)));
      w.hi = 32'(v + longint'($urandom_range(0, 2)) * Q_ONE -
                 longint'($urandom_range(0, 1)));
      w.cost = 32'(longint'($urandom_range(0, 200000)) - 100000);
    end
    return w;
  endfunction

  function automatic word_t row_word(int row);
    word_t w;
    longint r;
    w = blank_word(REQ_ROW);
    w.row = 6'(row);
    if ($urandom_range(0, 9) != 0) begin
      r = longint'($urandom_range(0, 2000000)) - 1000000;
      w.rhs = 32'(r);
      w.act = 32'(r - longint'($urandom_range(0, 300000)) +
                  longint'($urandom_range(0, 30000)));
    end
    return w;
  endfunction

  function automatic word_t coef_word(int row, int col);
    word_t w;
    int pick;
    w = blank_word(REQ_COEF);
    w.row = 6'(row);
    w.col = 6'(col);
    pick = $urandom_range(0, 9);
    if (pick < 3) w.coef = 0;
    else if (pick < 9)
      w.coef = 32'((longint'($urandom_range(0, 6)) - 3) * Q_ONE +
                   longint'($urandom_range(0, 255)));
    return w;
  endfunction

  function automatic word_t start_word();
    return blank_word(REQ_START);
  endfunction

  // index mostly within the counts in use
  function automatic int pick_index(int n);
    int lim;
    lim = n > 64 ? 64 : (n < 1 ? 1 : n);
    return ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63)
                                       : $urandom_range(0, lim - 1);
  endfunction

  // a random mix of loads and starts
  task automatic random_words(int n);
    word_t w;
    int pick;
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) w = coef_word(pick_index(row_count), pick_index(var_count));
      else if (pick < 60) w = row_word(pick_index(row_count));
      else if (pick < 88) w = var_word(pick_index(var_count));
      else w = start_word();
      paced_send(w);
    end
  endtask

  // fill every row and variable so no search reads an unwritten entry
  task automatic test_load_program();
    for (int k = 0; k < 64; k++) begin
      paced_send(var_word(k));
      paced_send(row_word(k));
    end
    drain();
  endtask

  // field extremes, register extremes and the special cases
  task automatic test_directed();
    word_t w;
    set_regs(4, 2, 0);
    // coefficient extremes
    w = coef_word(0, 0); w.coef = 32'sh8000_0000; send_word(w);
    w = coef_word(1, 1); w.coef = 32'sh7fff_ffff; send_word(w);
    w = coef_word(63, 63); w.coef = 32'sh7fff_ffff; send_word(w);
    // row extremes
    w = row_word(0); w.rhs = 32'sh7fff_ffff; w.act = 32'sh8000_0000; send_word(w);
    w = row_word(1); w.rhs = 32'sh8000_0000; w.act = 32'sh7fff_ffff; send_word(w);
    // variable extremes, wide bounds
    w = var_word(0); w.cost = 32'sh8000_0000; w.val = 0;
    w.lo = 32'sh8000_0000; w.hi = 32'sh7fff_ffff; send_word(w);
    w = var_word(1); w.cost = 32'sh7fff_ffff; w.val = 0;
    w.lo = 32'sh8000_0000; w.hi = 32'sh7fff_ffff; send_word(w);
    // equal costs tie; first in scan order wins
    w = var_word(2); w.cost = 1000; w.val = 0; w.lo = -32'sd65536; w.hi = 32'sd65536;
    send_word(w);
    w = var_word(3); w.cost = 1000; w.val = 0; w.lo = -32'sd65536; w.hi = 32'sd65536;
    send_word(w);
    send_word(start_word());
    // fresh search repeats the same answer
    send_word(start_word());
    drain();
    // no pairs at all
    set_regs(0, 0, 65535);
    send_word(start_word());
    drain();
    write_reg(CFG_VARS, 16'd1);
    send_word(start_word());
    drain();
    // all costs zero: nothing improves
    write_reg(CFG_VARS, 16'd2);
    w = var_word(0); w.cost = 0; send_word(w);
    w = var_word(1); w.cost = 0; send_word(w);
    send_word(start_word());
    drain();
    // counts beyond the stores clamp; unknown register index does nothing
    write_reg(CFG_UNUSED, 16'hffff);
    set_regs(127, 0, 0);
    send_word(start_word());
    drain();
    set_regs(3, 127, 65535);
    test_load_program();
    send_word(start_word());
    drain();
  endtask

  // random phases over several register settings
  task automatic test_random_phases();
    int nv, nr, t;
    for (int p = 0; p < 12; p++) begin
      nv = $urandom_range(2, 8);
      nr = $urandom_range(0, 8);
      case (p % 4)
        0: t = 0;
        1: t = 65535;
        default: t = $urandom_range(0, 65535);
      endcase
      set_regs(nv, nr, t);
      random_words(130);
      paced_send(start_word());
      drain();
    end
  endtask

  // receiver holds off while the sender keeps going
  task automatic test_backpressure();
    set_regs(4, 4, 100);
    hold_request = 3000;
    @(posedge clk);
    send_word(start_word());
    random_words(30);
    send_word(start_word());
    random_words(20);
    send_word(start_word());
    drain();
  endtask

  // the full-size search, run once
  task automatic test_full_size();
    set_regs(64, 64, 1);
    random_words(40);
    send_word(start_word());
    drain();
  endtask

  // result checker
  always @(posedge clk) begin
    move_t e;
    if (!rst && res_valid && !res_stall) begin
      results_seen++;
      if (best_moves.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word at cycle %0d", cycles);
      end else begin
        e = best_moves.pop_front();
        if (e.found) moves_seen++;
        if (move_found !== e.found || delta_objective !== e.delta ||
            first_var !== e.fvar || second_var !== e.svar ||
            first_step !== e.fstep || second_step !== e.sstep) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch cycle %0d: exp f=%0d d=%0d %0d/%0d %0d/%0d ",
                      "got f=%0d d=%0d %0d/%0d %0d/%0d"},
                     cycles, e.found, e.delta, e.fvar, e.svar, e.fstep, e.sstep,
                     move_found, delta_objective, first_var, second_var,
                     first_step, second_step);
        end
      end
    end
  end

  // sequence of tests
  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    req_type = '0; row_index = '0; var_index = '0;
    coef_value = '0; rhs_value = '0; activity_value = '0; cost_value = '0;
    current_value = '0; lower_bound = '0; upper_bound = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    cycles = 0; mismatches = 0; words_sent = 0; searches_sent = 0;
    results_seen = 0; moves_seen = 0; hold_request = 0;
    nogap_mode = 0; burst_left = 0;
    for (int r = 0; r < 64; r++)
      for (int c = 0; c < 64; c++) coef_mem[r][c] = 0;
    var_count = 64; row_count = 64; tol = 1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_load_program();
    test_directed();
    test_random_phases();
    test_backpressure();
    test_full_size();
    drain();
    $display("covered %0d words, %0d searches, %0d results, %0d with a move",
             words_sent, searches_sent, results_seen, moves_seen);
    if (mismatches == 0 && best_moves.size() == 0)
      $display("integer_pair_move_search_core regression: pass");
    else begin
      $display("%0d mismatches, %0d results missing", mismatches, best_moves.size());
      $display("integer_pair_move_search_core regression: fail");
    end
    $finish;
  end

endmodule

>>> files.f
design/ipms_pkg.sv
design/ipms_ram.sv
design/ipms_cell.sv
design/integer_pair_move_search_core.sv
design/ipms_checker.sv
tb/integer_pair_move_search_core_test.sv
